@@ src/bdq_pkg.sv @@
package bdq_pkg;

  localparam int BDQ_MAX_DEPTH = 1024;
  localparam int CAP_W         = 11;
  localparam int WORD_W        = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_REAR   = 3'd3;
  localparam logic [2:0] ACT_PEEK       = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_APPEND
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [WORD_W-1:0]  word;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]                action;
    logic signed [WORD_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                      ok;
    logic signed [WORD_W-1:0]  front_word;
    logic signed [WORD_W-1:0]  rear_word;
    logic                      empty_res;
    logic                      full_res;
  } rsp_t;

endpackage

@@ src/bounded_double_ended_queue.sv @@
// Double-ended queue of signed 32-bit words built from two rows of MAX_DEPTH
// cells: one row keeps the entries ordered from the front at cell 0, the other
// from the rear at cell 0, so both ends and their neighbors sit at fixed cells.
// Each transaction's result appears in the output register on the next cycle;
// a new transaction is accepted every cycle unless the result side stalls.
// The user must write capacity through cfg_we and cfg_wdata only while the
// block is idle (not enforced by the block); the limit saturates at MAX_DEPTH.
// Storage needs no clearing; the block is ready in the first cycle after reset.
module bounded_double_ended_queue #(
  parameter int MAX_DEPTH = bdq_pkg::BDQ_MAX_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  bdq_pkg::req_t             req_data,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output bdq_pkg::rsp_t             rsp_data,
  input  logic                      cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0] cfg_wdata
);
  import bdq_pkg::*;

  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0]  capacity;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [LW-1:0]     limit;
  logic              accept;
  logic              empty;
  logic              full;
  logic              do_push_front;
  logic              do_push_rear;
  logic              do_pop_front;
  logic              do_pop_rear;
  cell_ctl_t         front_ctl;
  cell_ctl_t         rear_ctl;
  logic [WORD_W-1:0] front0;
  logic [WORD_W-1:0] front1;
  logic [WORD_W-1:0] rear0;
  logic [WORD_W-1:0] rear1;
  rsp_t              rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign limit = (LW'(capacity) > LW'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : LW'(capacity);
  assign empty = (count == '0);
  assign full  = (LW'(count) >= limit);

  always_comb begin
    do_push_front = (req_data.action == ACT_PUSH_FRONT) && !full;
    do_push_rear  = (req_data.action == ACT_PUSH_REAR) && !full;
    do_pop_front  = (req_data.action == ACT_POP_FRONT) && !empty;
    do_pop_rear   = (req_data.action == ACT_POP_REAR) && !empty;

    count_next = count;
    if (do_push_front || do_push_rear) begin
      count_next = count + CW'(1);
    end else if (do_pop_front || do_pop_rear) begin
      count_next = count - CW'(1);
    end

    front_ctl.word = req_data.value;
    rear_ctl.word  = req_data.value;
    front_ctl.op   = CELL_HOLD;
    rear_ctl.op    = CELL_HOLD;
    if (accept) begin
      if (do_push_front) begin
        front_ctl.op = CELL_SHIFT_UP;
        rear_ctl.op  = CELL_APPEND;
      end else if (do_push_rear) begin
        front_ctl.op = CELL_APPEND;
        rear_ctl.op  = CELL_SHIFT_UP;
      end else if (do_pop_front) begin
        front_ctl.op = CELL_SHIFT_DOWN;
      end else if (do_pop_rear) begin
        rear_ctl.op  = CELL_SHIFT_DOWN;
      end
    end

    rsp_next.ok = do_push_front || do_push_rear || do_pop_front || do_pop_rear ||
                  (req_data.action == ACT_PEEK);

    if (count_next == '0) begin
      rsp_next.front_word = '1;
      rsp_next.rear_word  = '1;
    end else begin
      if (do_push_front || (do_push_rear && empty)) begin
        rsp_next.front_word = req_data.value;
      end else if (do_pop_front) begin
        rsp_next.front_word = front1;
      end else begin
        rsp_next.front_word = front0;
      end
      if (do_push_rear || (do_push_front && empty)) begin
        rsp_next.rear_word = req_data.value;
      end else if (do_pop_rear) begin
        rsp_next.rear_word = rear1;
      end else begin
        rsp_next.rear_word = rear0;
      end
    end

    rsp_next.empty_res = (count_next == '0);
    rsp_next.full_res  = (LW'(count_next) >= limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= rsp_next;
    end
  end

  bdq_chain #(
    .DEPTH (MAX_DEPTH),
    .CW    (CW)
  ) u_front_chain (
    .clk   (clk),
    .ctl   (front_ctl),
    .count (count),
    .word0 (front0),
    .word1 (front1)
  );

  bdq_chain #(
    .DEPTH (MAX_DEPTH),
    .CW    (CW)
  ) u_rear_chain (
    .clk   (clk),
    .ctl   (rear_ctl),
    .count (count),
    .word0 (rear0),
    .word1 (rear1)
  );

endmodule

@@ src/bdq_cell.sv @@
module bdq_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 11
) (
  input  logic                                 clk,
  input  bdq_pkg::cell_ctl_t                   ctl,
  input  logic [CW-1:0]                        count,
  input  logic [bdq_pkg::WORD_W-1:0]           from_lo,
  input  logic [bdq_pkg::WORD_W-1:0]           from_hi,
  output logic [bdq_pkg::WORD_W-1:0]           word
);
  import bdq_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_SHIFT_UP: begin
        word <= from_lo;
      end
      CELL_SHIFT_DOWN: begin
        word <= from_hi;
      end
      CELL_APPEND: begin
        if (count == CW'(INDEX)) begin
          word <= ctl.word;
        end
      end
    endcase
  end

endmodule

@@ src/bdq_chain.sv @@
module bdq_chain #(
  parameter int DEPTH = 1024,
  parameter int CW    = 11
) (
  input  logic                        clk,
  input  bdq_pkg::cell_ctl_t          ctl,
  input  logic [CW-1:0]               count,
  output logic [bdq_pkg::WORD_W-1:0]  word0,
  output logic [bdq_pkg::WORD_W-1:0]  word1
);
  import bdq_pkg::*;

  logic [WORD_W-1:0] w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;

    if (i == 0) begin : g_first
      assign lo = ctl.word;
    end else begin : g_mid_lo
      assign lo = w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign hi = w[i];
    end else begin : g_mid_hi
      assign hi = w[i+1];
    end

    bdq_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .count   (count),
      .from_lo (lo),
      .from_hi (hi),
      .word    (w[i])
    );
  end

  assign word0 = w[0];
  assign word1 = w[1];

endmodule

@@ src/bdq_checker.sv @@
module bdq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_stall,
  input logic                      rsp_valid,
  input logic                      rsp_stall,
  input bdq_pkg::rsp_t             rsp_data
);
  import bdq_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed or dropped");

  a_req_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted transaction produced no response");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a blocked response");

  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.empty_res |->
      (rsp_data.front_word == '1) && (rsp_data.rear_word == '1))
    else $error("empty response carries words");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (.*);
